// File: rtl/dri_pkg.sv
// types, constants and helpers shared by the damage rectangle to byte interval block
`timescale 1ns / 1ps

package dri_pkg;

  localparam int DIM_W      = 14;
  localparam int STRIDE_W   = 16;
  localparam int OFS_W      = 31;
  localparam int BPP_W      = 3;
  localparam int XF_W       = 4;
  localparam int SCALE_W    = 4;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int YP_W       = STRIDE_W + DIM_W;
  localparam int XP_W       = BPP_W + DIM_W;
  localparam int SUM_W      = OFS_W + 1;
  localparam int Q_DEPTH    = 2;
  localparam int Q_CNT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_CODE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR    = 3'd6;

  localparam logic [31:0]      XFORM_MAGIC = 32'h1472_3650;
  localparam logic [OUT_W-1:0] INT32_MIN_C = 32'h8000_0000;
  localparam logic [OUT_W-1:0] INT32_MAX_C = 32'h7FFF_FFFF;
  localparam logic [OFS_W-1:0] OFS_MAX     = '1;
  localparam logic [BPP_W-1:0] BPP_MAX     = 3'd4;
  localparam logic [BPP_W-1:0] BPP_RESET   = 3'd4;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;

  typedef struct packed {
    logic [DIM_W-1:0]    buffer_width;
    logic [DIM_W-1:0]    buffer_height;
    logic [STRIDE_W-1:0] row_stride;
    logic [OFS_W-1:0]    base_offset;
    logic [BPP_W-1:0]    bytes_per_pixel;
    logic [XF_W-1:0]     transform_code;
    logic [SCALE_W-1:0]  scale_factor;
  } dri_cfg_t;

  // one classified, clipped rectangle
  typedef struct packed {
    logic [DIM_W-1:0] xl;
    logic [DIM_W-1:0] xh;
    logic [DIM_W-1:0] yl;
    logic [DIM_W-1:0] yh;
    logic             contrib;
    logic             last;
    logic             bpp_bad;
  } dri_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dri_qstat_t;

  // bit 0 axis exchange, bit 1 x reflection, bit 2 y reflection
  function automatic logic [2:0] xform_flags(input logic [2:0] code);
    logic [31:0] sh;
    sh = XFORM_MAGIC >> {code, 2'b00};
    return sh[2:0];
  endfunction

endpackage

// File: rtl/dri_in_if.sv
// rectangle input channel
`timescale 1ns / 1ps

interface dri_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic signed [COORD_BITS-1:0] rect_width;
  logic signed [COORD_BITS-1:0] rect_height;
  logic                         in_buffer_coords;
  logic                         last_rect;

  modport source (
    output valid, rect_x, rect_y, rect_width, rect_height, in_buffer_coords, last_rect,
    input  ready
  );
  modport sink (
    input  valid, rect_x, rect_y, rect_width, rect_height, in_buffer_coords, last_rect,
    output ready
  );
endinterface

// File: rtl/dri_out_if.sv
// byte interval result channel
`timescale 1ns / 1ps

interface dri_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interval_low;
  logic signed [31:0] interval_high;
  logic               interval_empty;
  logic               whole_buffer;

  modport source (
    output valid, interval_low, interval_high, interval_empty, whole_buffer,
    input  ready
  );
  modport sink (
    input  valid, interval_low, interval_high, interval_empty, whole_buffer,
    output ready
  );
endinterface

// File: rtl/damage_rect_to_byte_interval.sv
// top level: configuration registers, front end, queue and back end
`timescale 1ns / 1ps

// Takes one damage rectangle per clock and reports, on the rectangle marked last,
// the byte interval of the buffer that the commit touched. Sustained rate is one
// rectangle per cycle unless a result waits: the front end scales, transforms and
// clips in the cycle of acceptance, and the back end's product stage and min/max
// stage each take one item per cycle. A result goes from the queue through the
// product stage into the output register; a waiting result holds back the next
// last rectangle and all behind it. Input ready drops only when the two-entry
// queue between front and back end is full. The user must write configuration
// registers via the cfg port with no commit in flight; the block does not check.

module damage_rect_to_byte_interval #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dri_in_if.sink                               in_rect,
  dri_out_if.source                            out_intv,
  input  logic                                 cfg_wr_en,
  input  logic [dri_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dri_pkg::CFG_DATA_W-1:0]       cfg_data
);

  dri_pkg::dri_cfg_t   cfg_r;
  dri_pkg::dri_entry_t f_entry, q_entry;
  dri_pkg::dri_qstat_t q_stat;
  logic                f_push, b_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_width    <= '0;
      cfg_r.buffer_height   <= '0;
      cfg_r.row_stride      <= '0;
      cfg_r.base_offset     <= '0;
      cfg_r.bytes_per_pixel <= dri_pkg::BPP_RESET;
      cfg_r.transform_code  <= '0;
      cfg_r.scale_factor    <= dri_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dri_pkg::REG_BUFFER_WIDTH:    cfg_r.buffer_width    <= cfg_data[dri_pkg::DIM_W-1:0];
        dri_pkg::REG_BUFFER_HEIGHT:   cfg_r.buffer_height   <= cfg_data[dri_pkg::DIM_W-1:0];
        dri_pkg::REG_ROW_STRIDE:      cfg_r.row_stride      <= cfg_data[dri_pkg::STRIDE_W-1:0];
        dri_pkg::REG_BASE_OFFSET:     cfg_r.base_offset     <= cfg_data[dri_pkg::OFS_W-1:0];
        dri_pkg::REG_BYTES_PER_PIXEL: cfg_r.bytes_per_pixel <= cfg_data[dri_pkg::BPP_W-1:0];
        dri_pkg::REG_TRANSFORM_CODE:  cfg_r.transform_code  <= cfg_data[dri_pkg::XF_W-1:0];
        dri_pkg::REG_SCALE_FACTOR:    cfg_r.scale_factor    <= cfg_data[dri_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dri_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_rect (in_rect),
    .cfg     (cfg_r),
    .q_full  (q_stat.full),
    .q_push  (f_push),
    .q_data  (f_entry)
  );

  dri_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_data (f_entry),
    .pop     (b_pop),
    .rd_data (q_entry),
    .status  (q_stat)
  );

  dri_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (!q_stat.empty),
    .q_data   (q_entry),
    .q_pop    (b_pop),
    .out_intv (out_intv)
  );

  // an accepted item is in the queue at the next edge
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_rect.valid && in_rect.ready |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  // the queue never pops while empty
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !b_pop)
    else $error("pop from empty queue");

  // empty and whole-buffer marks are exclusive
  a_marks_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_intv.valid |-> !(out_intv.interval_empty && out_intv.whole_buffer))
    else $error("empty and whole-buffer both set");

  // an ordinary interval never has a negative low end
  a_low_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_intv.valid && !out_intv.whole_buffer |-> !out_intv.interval_low[31])
    else $error("negative interval low without whole-buffer mark");

endmodule

// File: rtl/dri_front.sv
// front end: scales, transforms, clips and classifies each rectangle
`timescale 1ns / 1ps

module dri_front #(
  parameter int COORD_BITS = 16
) (
  dri_in_if.sink                  in_rect,
  input  dri_pkg::dri_cfg_t       cfg,
  input  logic                    q_full,
  output logic                    q_push,
  output dri_pkg::dri_entry_t     q_data
);

  // room for a scaled end corner reflected against a full-size buffer edge
  localparam int SW = (COORD_BITS + 6 > 16) ? COORD_BITS + 6 : 16;
  localparam int DW = dri_pkg::DIM_W;

  function automatic logic [DW-1:0] clip_dim(input logic signed [SW-1:0] v,
                                             input logic [DW-1:0] lim);
    logic signed [SW-1:0] lim_s;
    lim_s = $signed({{(SW-DW){1'b0}}, lim});
    if (v[SW-1]) begin
      clip_dim = '0;
    end else if (v > lim_s) begin
      clip_dim = lim;
    end else begin
      clip_dim = v[DW-1:0];
    end
  endfunction

  logic signed [SW-1:0] xe, ye, we, he, x_end, y_end, scl;
  logic signed [SW-1:0] bw_s, bh_s, ew, eh;
  logic signed [SW-1:0] ax0, axh0, ay0, ayh0, ax1, axh1, ay1, ayh1;
  logic signed [SW-1:0] xl_s, xh_s, yl_s, yh_s;
  logic [2:0]           flags;
  logic                 bpp_ok;

  assign in_rect.ready = !q_full;
  assign q_push        = in_rect.valid && !q_full;

  always_comb begin
    xe    = {{(SW-COORD_BITS){in_rect.rect_x[COORD_BITS-1]}}, in_rect.rect_x};
    ye    = {{(SW-COORD_BITS){in_rect.rect_y[COORD_BITS-1]}}, in_rect.rect_y};
    we    = {{(SW-COORD_BITS){in_rect.rect_width[COORD_BITS-1]}}, in_rect.rect_width};
    he    = {{(SW-COORD_BITS){in_rect.rect_height[COORD_BITS-1]}}, in_rect.rect_height};
    x_end = xe + we;
    y_end = ye + he;
    scl   = $signed({{(SW-dri_pkg::SCALE_W){1'b0}}, cfg.scale_factor});
    bw_s  = $signed({{(SW-DW){1'b0}}, cfg.buffer_width});
    bh_s  = $signed({{(SW-DW){1'b0}}, cfg.buffer_height});
    flags = dri_pkg::xform_flags(cfg.transform_code[2:0]);

    ew = flags[0] ? bh_s : bw_s;
    eh = flags[0] ? bw_s : bh_s;

    ax0  = xe * scl;
    axh0 = x_end * scl;
    ay0  = ye * scl;
    ayh0 = y_end * scl;

    // reflection maps [a, b) to [e - b, e - a)
    if (flags[1]) begin
      ax1  = ew - axh0;
      axh1 = ew - ax0;
    end else begin
      ax1  = ax0;
      axh1 = axh0;
    end
    if (flags[2]) begin
      ay1  = eh - ayh0;
      ayh1 = eh - ay0;
    end else begin
      ay1  = ay0;
      ayh1 = ayh0;
    end

    if (in_rect.in_buffer_coords) begin
      xl_s = xe;
      xh_s = x_end;
      yl_s = ye;
      yh_s = y_end;
    end else if (flags[0]) begin
      xl_s = ay1;
      xh_s = ayh1;
      yl_s = ax1;
      yh_s = axh1;
    end else begin
      xl_s = ax1;
      xh_s = axh1;
      yl_s = ay1;
      yh_s = ayh1;
    end

    bpp_ok = (cfg.bytes_per_pixel != '0) && (cfg.bytes_per_pixel <= dri_pkg::BPP_MAX);

    q_data.xl      = clip_dim(xl_s, cfg.buffer_width);
    q_data.xh      = clip_dim(xh_s, cfg.buffer_width);
    q_data.yl      = clip_dim(yl_s, cfg.buffer_height);
    q_data.yh      = clip_dim(yh_s, cfg.buffer_height);
    q_data.contrib = bpp_ok && (cfg.scale_factor != '0) && !cfg.transform_code[3];
    q_data.last    = in_rect.last_rect;
    q_data.bpp_bad = !bpp_ok;
  end

endmodule

// File: rtl/dri_queue.sv
// two-entry queue between front end and back end
`timescale 1ns / 1ps

module dri_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dri_pkg::dri_entry_t wr_data,
  input  logic                pop,
  output dri_pkg::dri_entry_t rd_data,
  output dri_pkg::dri_qstat_t status
);

  dri_pkg::dri_entry_t         mem_r [dri_pkg::Q_DEPTH];
  logic                        wr_ptr_r;
  logic                        rd_ptr_r;
  logic [dri_pkg::Q_CNT_W-1:0] count_r;
  logic [dri_pkg::Q_CNT_W-1:0] count_nxt;

  assign count_nxt    = count_r + {{(dri_pkg::Q_CNT_W-1){1'b0}}, push}
                                - {{(dri_pkg::Q_CNT_W-1){1'b0}}, pop};
  assign rd_data      = mem_r[rd_ptr_r];
  assign status.full  = (count_r == dri_pkg::Q_CNT_W'(dri_pkg::Q_DEPTH));
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/dri_back.sv
// back end: byte offsets, running min/max and the result register
`timescale 1ns / 1ps

module dri_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dri_pkg::dri_cfg_t   cfg,
  input  logic                q_valid,
  input  dri_pkg::dri_entry_t q_data,
  output logic                q_pop,
  dri_out_if.source           out_intv
);

  localparam int XP_W  = dri_pkg::XP_W;
  localparam int YP_W  = dri_pkg::YP_W;
  localparam int OFS_W = dri_pkg::OFS_W;
  localparam int SUM_W = dri_pkg::SUM_W;
  localparam int DW    = dri_pkg::DIM_W;

  // product stage
  logic            m_valid_r;
  logic [XP_W-1:0] m_xlp_r, m_xhp_r;
  logic [YP_W-1:0] m_ylp_r, m_yhp_r;
  logic            m_contrib_r, m_last_r, m_bpp_bad_r;

  // running state
  logic [OFS_W-1:0] run_low_r, run_low_nxt;
  logic [OFS_W-1:0] run_high_r, run_high_nxt;
  logic             any_r, any_nxt;

  // result register
  logic                     out_valid_r;
  logic [dri_pkg::OUT_W-1:0] out_low_r, out_high_r;
  logic                     out_empty_r, out_whole_r;

  logic [SUM_W-1:0] lo_sum, hi_sum;
  logic [OFS_W-1:0] lo_sat, hi_sat;
  logic             a_go, m_load;

  // non-last items only touch the running state, so they pass a full result register
  assign a_go   = m_valid_r && (!m_last_r || !out_valid_r || out_intv.ready);
  assign m_load = !m_valid_r || a_go;
  assign q_pop  = q_valid && m_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_load) begin
      m_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_xlp_r     <= {{DW{1'b0}}, cfg.bytes_per_pixel} * {{dri_pkg::BPP_W{1'b0}}, q_data.xl};
      m_xhp_r     <= {{DW{1'b0}}, cfg.bytes_per_pixel} * {{dri_pkg::BPP_W{1'b0}}, q_data.xh};
      m_ylp_r     <= {{DW{1'b0}}, cfg.row_stride} * {{dri_pkg::STRIDE_W{1'b0}}, q_data.yl};
      m_yhp_r     <= {{DW{1'b0}}, cfg.row_stride} * {{dri_pkg::STRIDE_W{1'b0}}, q_data.yh};
      m_contrib_r <= q_data.contrib;
      m_last_r    <= q_data.last;
      m_bpp_bad_r <= q_data.bpp_bad;
    end
  end

  always_comb begin
    lo_sum = {1'b0, cfg.base_offset} + {{(SUM_W-YP_W){1'b0}}, m_ylp_r}
                                     + {{(SUM_W-XP_W){1'b0}}, m_xlp_r};
    hi_sum = {1'b0, cfg.base_offset} + {{(SUM_W-YP_W){1'b0}}, m_yhp_r}
                                     + {{(SUM_W-XP_W){1'b0}}, m_xhp_r};
    // saturate offsets past the signed 32-bit range
    lo_sat = lo_sum[SUM_W-1] ? dri_pkg::OFS_MAX : lo_sum[OFS_W-1:0];
    hi_sat = hi_sum[SUM_W-1] ? dri_pkg::OFS_MAX : hi_sum[OFS_W-1:0];

    run_low_nxt  = (m_contrib_r && (lo_sat < run_low_r)) ? lo_sat : run_low_r;
    run_high_nxt = (m_contrib_r && (hi_sat > run_high_r)) ? hi_sat : run_high_r;
    any_nxt      = any_r || m_contrib_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_low_r  <= dri_pkg::OFS_MAX;
      run_high_r <= '0;
      any_r      <= 1'b0;
    end else if (a_go) begin
      if (m_last_r) begin
        run_low_r  <= dri_pkg::OFS_MAX;
        run_high_r <= '0;
        any_r      <= 1'b0;
      end else begin
        run_low_r  <= run_low_nxt;
        run_high_r <= run_high_nxt;
        any_r      <= any_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_go && m_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_intv.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && m_last_r) begin
      if (m_bpp_bad_r) begin
        out_low_r   <= dri_pkg::INT32_MIN_C;
        out_high_r  <= dri_pkg::INT32_MAX_C;
        out_empty_r <= 1'b0;
        out_whole_r <= 1'b1;
      end else if (!any_nxt) begin
        out_low_r   <= '0;
        out_high_r  <= '0;
        out_empty_r <= 1'b1;
        out_whole_r <= 1'b0;
      end else begin
        out_low_r   <= {1'b0, run_low_nxt};
        out_high_r  <= {1'b0, run_high_nxt};
        out_empty_r <= 1'b0;
        out_whole_r <= 1'b0;
      end
    end
  end

  assign out_intv.valid          = out_valid_r;
  assign out_intv.interval_low   = $signed(out_low_r);
  assign out_intv.interval_high  = $signed(out_high_r);
  assign out_intv.interval_empty = out_empty_r;
  assign out_intv.whole_buffer   = out_whole_r;

endmodule
